[hw/rtl/ttcs_pkg.sv]
// Shared types and constants for the triangle transform, cull and shade block.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package ttcs_pkg;

    // Stream word layout.
    localparam int FIELD_W     = 16;
    localparam int IN_FIELDS   = 9;
    localparam int OUT_COORDS  = 6;
    localparam int SHADE_W     = 5;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 104;
    localparam int SHADE_LSB   = OUT_COORDS * FIELD_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_Z    = 3'd0,
        CFG_SIN_Z    = 3'd1,
        CFG_COS_X    = 3'd2,
        CFG_SIN_X    = 3'd3,
        CFG_PROJ_X   = 3'd4,
        CFG_PROJ_Y   = 3'd5,
        CFG_SCREEN_W = 3'd6,
        CFG_SCREEN_H = 3'd7
    } t_cfg_reg;

    localparam logic [SHADE_W-1:0] SHADE_WHITE = 5'd24;
    localparam int                 Z_OFFSET    = 10240;

    // floor(u / 5) = (u * DIV5_MUL) >> DIV5_SHIFT for every u below 2^22.
    localparam logic [19:0] DIV5_MUL   = 20'd838861;
    localparam int          DIV5_SHIFT = 22;

endpackage

`default_nettype wire

[hw/rtl/triangle_transform_cull_shade_top.sv]
// Triangle geometry pipeline: rotate, cull, flat-shade and project one triangle.
// Depends on ttcs_pkg for the word layout, register indexes and constants.
//
// Usage: one triangle (nine Q4.12 coordinates) enters as one slave word per
// cycle on s_axis_* while s_axis_tready is high. Each triangle that survives
// culling leaves as one master word on m_axis_* with six saturated pixel
// coordinates and a grey level; a culled triangle (zero normal or facing away)
// yields no word at all. The pipeline depth is set by the projection quotient,
// which is formed one bit per pipeline stage, six of them side by side. A new
// triangle can be taken in every cycle that s_axis_tready is high, and words
// leave in input order.
// The configuration port writes one register per cycle with i_cfg_wen; write
// it only while no triangle is in flight. Reset loads the default rotation
// (identity), scales of 1.0 and a 256 by 256 screen, and empties the pipeline.
// When the receiver stalls, the output word holds and one further word is
// parked in a second output register; only when both are full does
// s_axis_tready fall and the whole pipeline freeze, so nothing is lost.
`default_nettype none

module triangle_transform_cull_shade_top #(
    parameter int COORD_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Fields from bit 0 up: ax, ay, az, bx, by_coord, bz, cx, cy, cz.
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [ttcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0 up: sax, say, sbx, sby, scx, scy, shade, zero pad.
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [ttcs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire                                 i_cfg_wen,
    input  wire  [ttcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [ttcs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int CB    = COORD_BITS;
    localparam int CW    = CB + 2;                       // rotated coordinate
    localparam int ES    = (CB > 16) ? CB - 16 : 0;      // edge pre-shift
    localparam int EW    = CW + 1 - ES;                  // edge vector
    localparam int R0W   = CW - ES;                      // scaled v0
    localparam int NNW   = 2 * EW + 1;                   // exact normal
    localparam int NNX   = (NNW > 25) ? NNW : 25;
    localparam int SHMAX = NNX - 25;
    localparam int SHW   = (SHMAX > 0) ? $clog2(SHMAX + 1) : 1;
    localparam int DTW   = NNX + R0W + 2;                // dot product
    localparam int RW    = CW + 17;                      // rotation sums
    localparam int PW    = CW + 17;                      // coord times scale
    localparam int QX    = (PW + 1 > 42) ? PW + 1 : 42;
    localparam int LAST  = PW + 10;                      // last pipeline stage
    localparam int GEO   = 12;                           // shade/cull ready
    localparam int GD    = LAST - GEO;
    localparam int FW    = ttcs_pkg::FIELD_W;

    localparam logic signed [RW-1:0] C_MAX = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [RW-1:0] C_MIN = ~C_MAX;
    localparam logic signed [QX-1:0] Q_HI  = QX'(64'sh100_0000_0000);
    localparam logic signed [QX-1:0] Q_LO  = -Q_HI;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0]                 r_cos_z, r_sin_z, r_cos_x, r_sin_x;
    logic [15:0]                        r_proj_x, r_proj_y;
    logic [ttcs_pkg::DIM_W-1:0]         r_scr_w, r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_z  <= 16'sh4000;
            r_sin_z  <= '0;
            r_cos_x  <= 16'sh4000;
            r_sin_x  <= '0;
            r_proj_x <= 16'd4096;
            r_proj_y <= 16'd4096;
            r_scr_w  <= 13'd256;
            r_scr_h  <= 13'd256;
        end else if (i_cfg_wen) begin
            unique case (ttcs_pkg::t_cfg_reg'(i_cfg_index))
                ttcs_pkg::CFG_COS_Z:    r_cos_z  <= $signed(i_cfg_wdata);
                ttcs_pkg::CFG_SIN_Z:    r_sin_z  <= $signed(i_cfg_wdata);
                ttcs_pkg::CFG_COS_X:    r_cos_x  <= $signed(i_cfg_wdata);
                ttcs_pkg::CFG_SIN_X:    r_sin_x  <= $signed(i_cfg_wdata);
                ttcs_pkg::CFG_PROJ_X:   r_proj_x <= i_cfg_wdata;
                ttcs_pkg::CFG_PROJ_Y:   r_proj_y <= i_cfg_wdata;
                ttcs_pkg::CFG_SCREEN_W: r_scr_w  <= i_cfg_wdata[ttcs_pkg::DIM_W-1:0];
                ttcs_pkg::CFG_SCREEN_H: r_scr_h  <= i_cfg_wdata[ttcs_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [CW-1:0] f_satc(input logic signed [RW-1:0] t);
        logic signed [CW-1:0] res;
        if (t > C_MAX) begin
            res = C_MAX[CW-1:0];
        end else if (t < C_MIN) begin
            res = C_MIN[CW-1:0];
        end else begin
            res = t[CW-1:0];
        end
        return res;
    endfunction

    // Round half up at 2^-14, then saturate.
    function automatic logic signed [CW-1:0] f_rot(input logic signed [RW-1:0] s);
        logic signed [RW-1:0] t;
        t = (s + RW'(8192)) >>> 14;
        return f_satc(t);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic w_en;
    logic r_v [1:LAST];
    logic r_out_v, r_skid_v;
    logic [ttcs_pkg::OUT_TDATA_W-1:0] r_out_data, r_skid_data;
    logic w_last_v;
    logic [ttcs_pkg::OUT_TDATA_W-1:0] w_last_data;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[1] <= s_axis_tvalid;
            for (int k = 2; k <= LAST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic signed [CB-1:0] w_in [3][3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_vin
        for (genvar gj = 0; gj < 3; gj++) begin : g_cin
            if (CB <= FW) begin : g_narrow
                assign w_in[gi][gj] = $signed(s_axis_tdata[FW*(3*gi+gj) +: CB]);
            end else begin : g_wide
                assign w_in[gi][gj] =
                    $signed({{(CB-FW){1'b0}}, s_axis_tdata[FW*(3*gi+gj) +: FW]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-4: rotation about Z, then about X, then the z offset
    // ------------------------------------------------------------------
    logic signed [CB+15:0] r_s1_p [3][4];
    logic signed [CB-1:0]  r_s1_z [3];
    logic signed [CW-1:0]  r_s2_x [3], r_s2_y [3];
    logic signed [CB-1:0]  r_s2_z [3];
    logic signed [CW-1:0]  r_s3_x [3];
    logic signed [CW+15:0] r_s3_p [3][4];
    logic signed [CW-1:0]  r_s4_v [3][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_p[i][0] <= w_in[i][0] * r_cos_z;
                r_s1_p[i][1] <= w_in[i][1] * r_sin_z;
                r_s1_p[i][2] <= w_in[i][0] * r_sin_z;
                r_s1_p[i][3] <= w_in[i][1] * r_cos_z;
                r_s1_z[i]    <= w_in[i][2];

                r_s2_x[i] <= f_rot(RW'(r_s1_p[i][0]) - RW'(r_s1_p[i][1]));
                r_s2_y[i] <= f_rot(RW'(r_s1_p[i][2]) + RW'(r_s1_p[i][3]));
                r_s2_z[i] <= r_s1_z[i];

                r_s3_x[i]    <= r_s2_x[i];
                r_s3_p[i][0] <= r_s2_y[i] * r_cos_x;
                r_s3_p[i][1] <= r_s2_z[i] * r_sin_x;
                r_s3_p[i][2] <= r_s2_y[i] * r_sin_x;
                r_s3_p[i][3] <= r_s2_z[i] * r_cos_x;

                r_s4_v[i][0] <= r_s3_x[i];
                r_s4_v[i][1] <= f_rot(RW'(r_s3_p[i][0]) - RW'(r_s3_p[i][1]));
                r_s4_v[i][2] <= f_satc(RW'(f_rot(RW'(r_s3_p[i][2]) + RW'(r_s3_p[i][3])))
                                       + RW'(ttcs_pkg::Z_OFFSET));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 5-12: face normal, cull decision and grey level
    // ------------------------------------------------------------------
    logic signed [EW-1:0]    r_g5_e1 [3], r_g5_e2 [3];
    logic signed [R0W-1:0]   r_g5_r0 [3], r_g6_r0 [3], r_g7_r0 [3];
    logic signed [2*EW-1:0]  r_g6_c [6];
    logic signed [NNX-1:0]   r_g7_n [3], r_g8_n [3];
    logic                    r_g7_zero, r_g8_zero;
    logic signed [DTW-1:0]   r_g8_dp [3];
    logic [SHW-1:0]          r_g8_sh;
    logic                    r_g9_cull, r_g9_aneg;
    logic [48:0]             r_g9_sq [3];
    logic [50:0]             r_g10_m;
    logic [57:0]             r_g10_a2;
    logic                    r_g10_cull, r_g10_aneg;
    logic [24:1]             r_g11_ge;
    logic                    r_g11_wb, r_g11_cull, r_g11_aneg;
    logic [ttcs_pkg::SHADE_W-1:0] r_g12_shade;
    logic                    r_g12_cull;
    logic [ttcs_pkg::SHADE_W-1:0] r_gd_shade [1:GD];
    logic                    r_gd_cull [1:GD];

    logic signed [CW:0]      w_ed1 [3], w_ed2 [3];
    logic signed [CW:0]      w_ed1s [3], w_ed2s [3];
    logic signed [CW-1:0]    w_r0s [3];
    logic [SHW-1:0]          w_sh;
    logic signed [NNX-1:0]   w_nsh [3];
    logic signed [24:0]      w_ns [3];
    logic signed [49:0]      w_sq [3];
    logic signed [DTW-1:0]   w_dot;
    logic [ttcs_pkg::SHADE_W-1:0] w_shade;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ed1[k]  = (CW+1)'(r_s4_v[1][k]) - (CW+1)'(r_s4_v[0][k]);
            w_ed2[k]  = (CW+1)'(r_s4_v[2][k]) - (CW+1)'(r_s4_v[0][k]);
            w_ed1s[k] = w_ed1[k] >>> ES;
            w_ed2s[k] = w_ed2[k] >>> ES;
            w_r0s[k]  = r_s4_v[0][k] >>> ES;
        end
    end

    // Least right shift that brings every normal component into 25 signed bits.
    always_comb begin
        logic signed [NNX-1:0] t;
        logic                  fits;
        w_sh = '0;
        for (int r = SHMAX; r >= 0; r--) begin
            fits = 1'b1;
            for (int k = 0; k < 3; k++) begin
                t = r_g7_n[k] >>> r;
                if (!((&t[NNX-1:24]) || !(|t[NNX-1:24]))) begin
                    fits = 1'b0;
                end
            end
            if (fits) begin
                w_sh = SHW'(r);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_nsh[k] = r_g8_n[k] >>> r_g8_sh;
            w_ns[k]  = w_nsh[k][24:0];
            w_sq[k]  = w_ns[k] * w_ns[k];
        end
        w_dot = r_g8_dp[0] + r_g8_dp[1] + r_g8_dp[2];
    end

    // The tests pass for every k up to the answer, so the last passing k wins.
    always_comb begin
        if (r_g11_aneg) begin
            w_shade = r_g11_wb ? ttcs_pkg::SHADE_WHITE : '0;
        end else begin
            w_shade = '0;
            for (int k = 1; k <= 24; k++) begin
                if (r_g11_ge[k]) begin
                    w_shade = ttcs_pkg::SHADE_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_g5_e1[k] <= w_ed1s[k][EW-1:0];
                r_g5_e2[k] <= w_ed2s[k][EW-1:0];
                r_g5_r0[k] <= w_r0s[k][R0W-1:0];
                r_g6_r0[k] <= r_g5_r0[k];
                r_g7_r0[k] <= r_g6_r0[k];
            end
            r_g6_c[0] <= r_g5_e1[1] * r_g5_e2[2];
            r_g6_c[1] <= r_g5_e1[2] * r_g5_e2[1];
            r_g6_c[2] <= r_g5_e1[2] * r_g5_e2[0];
            r_g6_c[3] <= r_g5_e1[0] * r_g5_e2[2];
            r_g6_c[4] <= r_g5_e1[0] * r_g5_e2[1];
            r_g6_c[5] <= r_g5_e1[1] * r_g5_e2[0];

            for (int k = 0; k < 3; k++) begin
                r_g7_n[k] <= NNX'(r_g6_c[2*k]) - NNX'(r_g6_c[2*k+1]);
            end
            r_g7_zero <= (r_g6_c[0] == r_g6_c[1]) && (r_g6_c[2] == r_g6_c[3])
                         && (r_g6_c[4] == r_g6_c[5]);

            for (int k = 0; k < 3; k++) begin
                r_g8_dp[k] <= r_g7_n[k] * r_g7_r0[k];
                r_g8_n[k]  <= r_g7_n[k];
            end
            r_g8_sh   <= w_sh;
            r_g8_zero <= r_g7_zero;

            r_g9_cull <= r_g8_zero || !w_dot[DTW-1];
            r_g9_aneg <= !w_ns[2][24] && (w_ns[2] != '0);
            for (int k = 0; k < 3; k++) begin
                r_g9_sq[k] <= w_sq[k][48:0];
            end

            r_g10_m    <= 51'(r_g9_sq[0]) + 51'(r_g9_sq[1]) + 51'(r_g9_sq[2]);
            r_g10_a2   <= {r_g9_sq[2], 9'd0} + {3'd0, r_g9_sq[2], 6'd0};
            r_g10_cull <= r_g9_cull;
            r_g10_aneg <= r_g9_aneg;

            for (int k = 1; k <= 24; k++) begin
                r_g11_ge[k] <= (60'(r_g10_m) * 60'(k * k)) <= 60'(r_g10_a2);
            end
            r_g11_wb   <= 60'(r_g10_a2) >= 60'(r_g10_m);
            r_g11_cull <= r_g10_cull;
            r_g11_aneg <= r_g10_aneg;

            r_g12_shade <= w_shade;
            r_g12_cull  <= r_g11_cull;

            r_gd_shade[1] <= r_g12_shade;
            r_gd_cull[1]  <= r_g12_cull;
            for (int k = 2; k <= GD; k++) begin
                r_gd_shade[k] <= r_gd_shade[k-1];
                r_gd_cull[k]  <= r_gd_cull[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 to LAST: projection, six lanes (x and y of each vertex)
    // ------------------------------------------------------------------
    logic [FW-1:0] w_lane_res [6];

    for (genvar gl = 0; gl < 6; gl++) begin : g_lane
        localparam int VI = gl / 2;
        localparam int AX = gl % 2;

        logic signed [PW-1:0]    r_pp;
        logic signed [CW-1:0]    r_pz;
        logic [PW-1:0]           r_dn  [0:PW];
        logic [CW-1:0]           r_dr  [0:PW];
        logic [CW-1:0]           r_dd  [0:PW];
        logic                    r_dz  [0:PW];
        logic                    r_dng [0:PW];
        logic signed [PW-13:0]   r_dq0 [0:PW];
        logic signed [41:0]      r_q1;
        logic signed [55:0]      r_q2;
        logic [18:0]             r_q3;
        logic [38:0]             r_q4;

        logic signed [QX-1:0]    w_qm, w_qs, w_qsel;
        logic signed [41:0]      w_qsat;
        logic signed [55:0]      w_y;
        logic signed [19:0]      w_yc;
        logic [15:0]             w_b;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pp <= (AX == 0) ? r_s4_v[VI][0] * $signed({1'b0, r_proj_x})
                                  : r_s4_v[VI][1] * $signed({1'b0, r_proj_y});
                r_pz <= r_s4_v[VI][2];

                // Sign and magnitude for the truncating divide.
                r_dn[0]  <= r_pp[PW-1] ? PW'(-r_pp) : PW'(r_pp);
                r_dd[0]  <= r_pz[CW-1] ? CW'(-r_pz) : CW'(r_pz);
                r_dr[0]  <= '0;
                r_dz[0]  <= (r_pz == '0);
                r_dng[0] <= r_pp[PW-1] ^ r_pz[CW-1];
                r_dq0[0] <= $signed(r_pp[PW-1:12]);
            end
        end

        // One restoring quotient bit per stage; quotient bits shift in below
        // the dividend bits still to be consumed.
        for (genvar gj = 1; gj <= PW; gj++) begin : g_div
            logic [CW:0] w_rin, w_diff;
            logic        w_qb;
            assign w_rin  = {r_dr[gj-1], r_dn[gj-1][PW-1]};
            assign w_diff = w_rin - {1'b0, r_dd[gj-1]};
            assign w_qb   = !w_diff[CW];

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dn[gj]  <= {r_dn[gj-1][PW-2:0], w_qb};
                    r_dr[gj]  <= w_qb ? w_diff[CW-1:0] : w_rin[CW-1:0];
                    r_dd[gj]  <= r_dd[gj-1];
                    r_dz[gj]  <= r_dz[gj-1];
                    r_dng[gj] <= r_dng[gj-1];
                    r_dq0[gj] <= r_dq0[gj-1];
                end
            end
        end

        always_comb begin
            w_qm   = $signed(QX'(r_dn[PW]));
            w_qs   = r_dng[PW] ? -w_qm : w_qm;
            w_qsel = r_dz[PW] ? QX'(r_dq0[PW]) : w_qs;
            if (w_qsel > Q_HI) begin
                w_qsat = Q_HI[41:0];
            end else if (w_qsel < Q_LO) begin
                w_qsat = Q_LO[41:0];
            end else begin
                w_qsat = w_qsel[41:0];
            end

            // Times 2 or 4, then floor by 4096, in one arithmetic shift.
            w_y = (AX == 0) ? (r_q2 >>> 11) : (r_q2 >>> 10);
            if (w_y > 56'sd163839) begin
                w_yc = 20'sd163839;
            end else if (w_y < -56'sd163840) begin
                w_yc = -20'sd163840;
            end else begin
                w_yc = w_y[19:0];
            end

            w_b = r_q4[ttcs_pkg::DIV5_SHIFT +: 16];
            // The offset of 5 * 32768 comes back out as a flip of the top bit.
            w_lane_res[gl] = {~w_b[15], w_b[14:0]};
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_q1 <= w_qsat;
                r_q2 <= (r_q1 + 56'sd4096)
                        * $signed({1'b0, (AX == 0) ? r_scr_w : r_scr_h});
                r_q3 <= 19'(w_yc + 20'sd163840);
                r_q4 <= 39'(r_q3) * 39'(ttcs_pkg::DIV5_MUL);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with one parking slot
    // ------------------------------------------------------------------
    assign w_last_v    = r_v[LAST] && !r_gd_cull[GD];
    assign w_last_data = {3'd0, r_gd_shade[GD], w_lane_res[5], w_lane_res[4],
                          w_lane_res[3], w_lane_res[2], w_lane_res[1], w_lane_res[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out_v <= w_last_v;
        end else if (w_last_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out_data <= w_last_data;
        end else begin
            r_skid_data <= w_last_data;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[hw/rtl/ttcs_checker.sv]
// Port-level checks for the triangle transform, cull and shade top level.
// Depends on ttcs_pkg; bound to triangle_transform_cull_shade_top below.
`default_nettype none

module ttcs_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire [ttcs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [ttcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // The grey level never exceeds white.
    a_shade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[ttcs_pkg::SHADE_LSB +: ttcs_pkg::SHADE_W] <= ttcs_pkg::SHADE_WHITE)
        else $error("shade out of range");

    // Reset leaves the pipeline empty and ready.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // The input side only backs up behind a waiting result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // One accepted result frees the parked word and reopens the input.
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input still stalled after the output drained");

endmodule

bind triangle_transform_cull_shade_top ttcs_checker u_ttcs_checker (.*);

`default_nettype wire

[test/tb.sv]
// Self-checking bench for triangle_transform_cull_shade_top: a bit-exact geometry
// predictor fills a queue of expected screen words, which the output stream drains.
// Depends on ttcs_pkg and the top-level RTL only.
`default_nettype none

module tb;

    localparam int LATENCY   = 45;
    localparam int WDOG_MAX  = 4000;

    typedef struct packed {
        logic [4:0]  shade;
        logic [15:0] scy, scx, sby, sbx, say, sax;
    } t_screen;

    // Geometry predictor with its own register copy.
    class tri_scoreboard;
        longint czr, szr, cxr, sxr, pxs, pys, wid, hgt;
        t_screen pending[$];
        int errors;

        function new();
            czr = 16384; szr = 0; cxr = 16384; sxr = 0;
            pxs = 4096; pys = 4096; wid = 256; hgt = 256;
            errors = 0;
        endfunction

        function void write_reg(ttcs_pkg::t_cfg_reg idx, logic [15:0] val);
            case (idx)
                ttcs_pkg::CFG_COS_Z:    czr = $signed(val);
                ttcs_pkg::CFG_SIN_Z:    szr = $signed(val);
                ttcs_pkg::CFG_COS_X:    cxr = $signed(val);
                ttcs_pkg::CFG_SIN_X:    sxr = $signed(val);
                ttcs_pkg::CFG_PROJ_X:   pxs = val;
                ttcs_pkg::CFG_PROJ_Y:   pys = val;
                ttcs_pkg::CFG_SCREEN_W: wid = val[12:0];
                ttcs_pkg::CFG_SCREEN_H: hgt = val[12:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint rnd14(longint p);
            return clip((p + 8192) >>> 14, -(64'sd1 <<< 17), (64'sd1 <<< 17) - 1);
        endfunction

        function longint to_screen(longint c, longint z, longint sc, longint dim,
                                   longint num);
            longint p, q, u;
            p = c * sc;
            if (z == 0) q = p >>> 12;
            else begin
                if (z < 0) begin
                    p = -p;
                    z = -z;
                end
                q = p / z;
            end
            q = clip(q, -(64'sd1 <<< 40), 64'sd1 <<< 40);
            u = (q + 4096) * dim * num;
            u = (u >= 0) ? u / 20480 : -((-u + 20479) / 20480);
            return clip(u, -32768, 32767);
        endfunction

        function void note_triangle(logic [ttcs_pkg::IN_TDATA_W-1:0] w);
            longint v[3][3], e1[3], e2[3], n[3], dotp, a, m2, a2, sh, x, y, z, x1, y1;
            int r;
            logic fits;
            t_screen res;
            for (int i = 0; i < 3; i++) begin
                x = $signed(w[48*i +: 16]);
                y = $signed(w[48*i+16 +: 16]);
                z = $signed(w[48*i+32 +: 16]);
                x1 = rnd14(x * czr - y * szr);
                y1 = rnd14(x * szr + y * czr);
                v[i][0] = x1;
                v[i][1] = rnd14(y1 * cxr - z * sxr);
                v[i][2] = clip(rnd14(y1 * sxr + z * cxr) + ttcs_pkg::Z_OFFSET,
                               -(64'sd1 <<< 17), (64'sd1 <<< 17) - 1);
            end
            for (int k = 0; k < 3; k++) begin
                e1[k] = v[1][k] - v[0][k];
                e2[k] = v[2][k] - v[0][k];
            end
            n[0] = e1[1] * e2[2] - e1[2] * e2[1];
            n[1] = e1[2] * e2[0] - e1[0] * e2[2];
            n[2] = e1[0] * e2[1] - e1[1] * e2[0];
            if (n[0] == 0 && n[1] == 0 && n[2] == 0) return;
            dotp = n[0] * v[0][0] + n[1] * v[0][1] + n[2] * v[0][2];
            if (dotp >= 0) return;
            for (r = 0; r < 62; r++) begin
                fits = 1'b1;
                for (int k = 0; k < 3; k++)
                    if ((n[k] >>> r) < -(64'sd1 <<< 24) || (n[k] >>> r) >= (64'sd1 <<< 24))
                        fits = 1'b0;
                if (fits) break;
            end
            for (int k = 0; k < 3; k++) n[k] = n[k] >>> r;
            a = -n[2];
            m2 = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
            a2 = 576 * a * a;
            sh = 0;
            if (a >= 0) begin
                for (int k = 1; k <= 24; k++)
                    if (k * k * m2 <= a2) sh = k;
            end else if (a2 >= m2) sh = ttcs_pkg::SHADE_WHITE;
            res.sax = 16'(to_screen(v[0][0], v[0][2], pxs, wid, 2));
            res.say = 16'(to_screen(v[0][1], v[0][2], pys, hgt, 4));
            res.sbx = 16'(to_screen(v[1][0], v[1][2], pxs, wid, 2));
            res.sby = 16'(to_screen(v[1][1], v[1][2], pys, hgt, 4));
            res.scx = 16'(to_screen(v[2][0], v[2][2], pxs, wid, 2));
            res.scy = 16'(to_screen(v[2][1], v[2][2], pys, hgt, 4));
            res.shade = 5'(sh);
            pending = {pending, res};
        endfunction

        function void check_word(logic [ttcs_pkg::OUT_TDATA_W-1:0] w);
            t_screen got, exp_w;
            got = w[100:0];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output word %h", w);
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w || w[103:101] !== 3'b0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h got %h", exp_w, w);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [ttcs_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [ttcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic i_cfg_wen = 0;
    logic [ttcs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ttcs_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    tri_scoreboard screen_sb = new();
    int send_idle_pct = 0, recv_stall_pct = 0;
    int idle_cycles = 0;

    triangle_transform_cull_shade_top uut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) screen_sb.note_triangle(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) screen_sb.check_word(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_wen)
                idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Leaves the word valid after acceptance; the next call replaces or clears it, and wait_empty clears it.
    task automatic send_triangle(logic [ttcs_pkg::IN_TDATA_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_empty();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (screen_sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(ttcs_pkg::t_cfg_reg idx, logic [15:0] val);
        i_cfg_wen   <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        screen_sb.write_reg(idx, val);
    endtask

    task automatic cfg_idle();
        i_cfg_wen <= 0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(8191) - 4096);
            default: return 16'($urandom_range(2047) - 1024);
        endcase
    endfunction

    // A random triangle: each coordinate is drawn full-range or from a small range near the origin.
    function automatic logic [ttcs_pkg::IN_TDATA_W-1:0] rand_triangle();
        logic [ttcs_pkg::IN_TDATA_W-1:0] w;
        for (int i = 0; i < 9; i++) w[16*i +: 16] = rand_coord();
        return w;
    endfunction

    function automatic logic [ttcs_pkg::IN_TDATA_W-1:0] pack_tri(int ax, int ay, int az,
            int bx, int by_c, int bz, int cx, int cy, int cz);
        return {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by_c), 16'(bx),
                16'(az), 16'(ay), 16'(ax)};
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: both windings, degenerate, z = 0 vertex, extremes.
        send_triangle(pack_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_triangle(pack_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
        send_triangle(pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(pack_tri(0, 0, -10240, 4096, 0, 0, 0, 4096, 0));
        send_triangle(pack_tri(-4096, -4096, 0, 4096, -4096, 0, 0, 4096, 0));
        send_triangle(pack_tri(-4096, -4096, 0, 0, 4096, 0, 4096, -4096, 0));
        send_triangle(pack_tri(0, 0, 0, 4096, 0, 4096, 0, 4096, 0));
        send_triangle(pack_tri(0, 0, 0, 4096, 0, -4096, 0, 4096, 4096));
        send_triangle({9{16'h8000}});
        send_triangle({9{16'h7fff}});
        send_triangle(pack_tri(-32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 0));
        send_triangle(pack_tri(32767, -32768, 32767, -32768, 0, -32768, 0, 32767, 0));
        send_triangle({144{1'b1}});
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (ph)
                0: ;
                1: begin
                    write_reg(ttcs_pkg::CFG_COS_Z, 16'(-16384));
                    write_reg(ttcs_pkg::CFG_SIN_Z, 16'd0);
                    write_reg(ttcs_pkg::CFG_PROJ_X, 16'hffff);
                    write_reg(ttcs_pkg::CFG_PROJ_Y, 16'd0);
                    write_reg(ttcs_pkg::CFG_SCREEN_W, 16'd4096);
                    write_reg(ttcs_pkg::CFG_SCREEN_H, 16'd1);
                end
                2: begin
                    write_reg(ttcs_pkg::CFG_COS_X, 16'd0);
                    write_reg(ttcs_pkg::CFG_SIN_X, 16'd16384);
                    write_reg(ttcs_pkg::CFG_SCREEN_W, 16'd0);
                    write_reg(ttcs_pkg::CFG_SCREEN_H, 16'h1fff);
                end
                3: begin
                    write_reg(ttcs_pkg::CFG_SIN_X, 16'(-16384));
                    write_reg(ttcs_pkg::CFG_SIN_Z, 16'h7fff);
                    write_reg(ttcs_pkg::CFG_PROJ_Y, 16'hffff);
                    write_reg(ttcs_pkg::CFG_SCREEN_H, 16'd0);
                end
                default: for (int r = 0; r < 8; r++)
                    write_reg(ttcs_pkg::t_cfg_reg'(r),
                              (r < 4) ? 16'($urandom_range(32768) - 16384)
                                      : 16'($urandom));
            endcase
            cfg_idle();
            for (int i = 0; i < 155; i++) begin
                send_triangle(rand_triangle());
                if (i == 80) begin
                    // Hold the sender until every expected word has come out.
                    wait_empty();
                end
            end
            drain();
        end

        if (screen_sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

[triangle_transform_cull_shade_top.f]
hw/rtl/ttcs_pkg.sv
hw/rtl/triangle_transform_cull_shade_top.sv
hw/rtl/ttcs_checker.sv
test/tb.sv
